FILE: rtl/core/ssmp_pkg.sv
// shared types and constants of the stratified sample median pivot block
package ssmp_pkg;
	localparam int MAX_SAMPLES = 63;
	localparam int ELEM_W      = 32;
	localparam int POS_W       = 32;
	localparam int CNT_W       = 6;
	localparam int SEED_W      = 31;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int SIDX_W      = $clog2(MAX_SAMPLES);

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_INC = 32'd12345;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 2'd1;

	// one input beat
	typedef struct packed {
		logic                     first;
		logic [POS_W-1:0]         length;
		logic signed [ELEM_W-1:0] value;
	} item_t;

	// one held sample
	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic [POS_W-1:0]         position;
	} sample_t;
endpackage

FILE: rtl/core/ssmp_ram.sv
// generic single write port ram with registered read
module ssmp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/ssmp_front.sv
// front end: accepts input beats into a two entry queue
module ssmp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ssmp_pkg::item_t in_item,
	output logic           q_valid,
	output ssmp_pkg::item_t q_item,
	input  logic           q_pop
);
	import ssmp_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       push, pop;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 2'd0 |=> fill_q != 2'd3) else $error("queue underflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid || fill_q == 2'd0) else $error("pop without data");
endmodule

FILE: rtl/core/ssmp_div.sv
// restoring divider, one quotient bit per cycle
module ssmp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	logic [32:0] rem_q;
	logic [31:0] quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted, diff;

	assign shifted   = {rem_q[31:0], quo_q[31]};
	assign diff      = shifted - {1'b0, dvs_q};
	assign quotient  = quo_q;
	assign remainder = rem_q[31:0];

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("done without work");
	a_done_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("busy after done");
endmodule

FILE: rtl/core/ssmp_back.sv
// back end: stratum draw, sample insertion and pivot output
module ssmp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [ssmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               q_valid,
	input  ssmp_pkg::item_t                    q_item,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ssmp_pkg::ELEM_W-1:0] pivot_value,
	output logic [ssmp_pkg::POS_W-1:0]         pivot_index
);
	import ssmp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_W, S_AIM1, S_AIM2, S_AIM3, S_CHECK,
		S_INS_RD, S_INS_CMP, S_INS_WR, S_FIN, S_OUT_RD, S_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_reg_q, eff_q, num_q;
	logic [SIDX_W-1:0] j_q;
	logic [SEED_W-1:0] lcg_q;
	logic [POS_W-1:0]  pos_q, len_q, width_q, target_q, base_q;
	logic signed [ELEM_W-1:0] val_q;
	logic              ret_fin_q;

	logic              div_start, div_done;
	logic [31:0]       div_a, div_b, div_quo, div_rem;
	logic [POS_W-1:0]  in_len, span;
	logic [CNT_W-1:0]  in_cnt;
	logic [31:0]       lcg_prod;
	logic              ram_we;
	logic [SIDX_W-1:0] ram_waddr, ram_raddr;
	sample_t           ram_wdata, ram_rdata;
	logic              out_load;

	// array start: length and count clamping
	always_comb begin
		in_len = (q_item.length == '0) ? POS_W'(1) : q_item.length;
		in_cnt = (cnt_reg_q == '0) ? CNT_W'(1) : cnt_reg_q;
		if (POS_W'(in_cnt) > in_len) begin
			in_cnt = CNT_W'((in_len - POS_W'(1)) | POS_W'(1));
		end
	end

	assign span     = (num_q + CNT_W'(1) == eff_q) ? len_q - base_q : width_q;
	assign lcg_prod = {1'b0, lcg_q} * LCG_MUL;

	// shared divider: stratum width, then draw modulo span
	assign div_start = (state_q == S_IDLE && q_valid && q_item.first)
		|| (state_q == S_AIM2 && span != '0);
	assign div_a = (state_q == S_IDLE) ? in_len : {1'b0, lcg_q};
	assign div_b = (state_q == S_IDLE) ? POS_W'(in_cnt) : span;

	ssmp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sample store access
	assign ram_raddr = (state_q == S_INS_RD) ? j_q - SIDX_W'(1) : SIDX_W'(eff_q >> 1);
	assign ram_we    = (state_q == S_INS_CMP && ram_rdata.value > val_q)
		|| state_q == S_INS_WR;
	assign ram_waddr = j_q;
	assign ram_wdata = (state_q == S_INS_WR) ? sample_t'{val_q, pos_q} : ram_rdata;

	ssmp_ram #(.WIDTH($bits(sample_t)), .DEPTH(MAX_SAMPLES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign q_pop = (state_q == S_IDLE);

	// pivot register loads when empty or its beat leaves
	assign out_load = (state_q == S_OUT) && (!out_valid || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_reg_q <= CNT_W'(3);
			lcg_q     <= SEED_W'(1);
			eff_q     <= '0;
			num_q     <= '0;
			j_q       <= '0;
			pos_q     <= '0;
			len_q     <= '0;
			width_q   <= '0;
			target_q  <= '0;
			base_q    <= '0;
			val_q     <= '0;
			ret_fin_q <= 1'b0;
			out_valid   <= 1'b0;
			pivot_value <= '0;
			pivot_index <= '0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_SAMPLE_COUNT) cnt_reg_q <= cfg_data[CNT_W-1:0];
				if (cfg_index == CFG_SEED)         lcg_q     <= cfg_data[SEED_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						val_q <= q_item.value;
						if (q_item.first) begin
							len_q     <= in_len;
							eff_q     <= in_cnt;
							num_q     <= '0;
							pos_q     <= '0;
							ret_fin_q <= 1'b0;
							state_q   <= S_DIV_W;
						end else if (pos_q < len_q) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_DIV_W: begin
					if (div_done) begin
						width_q <= div_quo;
						state_q <= S_AIM1;
					end
				end
				S_AIM1: begin
					base_q  <= POS_W'(num_q) * width_q;
					lcg_q   <= SEED_W'(lcg_prod + LCG_INC);
					state_q <= S_AIM2;
				end
				S_AIM2: begin
					if (span == '0) begin
						target_q <= base_q;
						state_q  <= ret_fin_q ? S_FIN : S_CHECK;
					end else begin
						state_q <= S_AIM3;
					end
				end
				S_AIM3: begin
					if (div_done) begin
						target_q <= base_q + div_rem;
						state_q  <= ret_fin_q ? S_FIN : S_CHECK;
					end
				end
				S_CHECK: begin
					if (num_q < eff_q && pos_q == target_q) begin
						j_q     <= SIDX_W'(num_q);
						state_q <= (num_q == '0) ? S_INS_WR : S_INS_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (ram_rdata.value > val_q) begin
						j_q     <= j_q - SIDX_W'(1);
						state_q <= (j_q == SIDX_W'(1)) ? S_INS_WR : S_INS_RD;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					num_q <= num_q + CNT_W'(1);
					if (num_q + CNT_W'(1) < eff_q) begin
						ret_fin_q <= 1'b1;
						state_q   <= S_AIM1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					pos_q   <= pos_q + POS_W'(1);
					state_q <= (pos_q == len_q - POS_W'(1)) ? S_OUT_RD : S_IDLE;
				end
				S_OUT_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						pivot_value <= ram_rdata.value;
						pivot_index <= ram_rdata.position;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_num_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> num_q <= eff_q) else $error("stratum beyond count");
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_RD |-> j_q != '0 && j_q <= SIDX_W'(num_q))
		else $error("insert slot out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid && out_stall |=> state_q == S_OUT)
		else $error("pivot overwritten");
endmodule

FILE: rtl/core/stratified_sample_median_pivot.sv
// Streams array elements and returns the median of one random sample per stratum.
// Each element that is not sampled passes the idle, check and finish states; a
// sampled element adds a store write, a read and compare per held sample it is
// compared with (one read port, registered) and, when another stratum follows,
// the next draw through the 32 step bit-serial divider that takes the draw modulo
// the stratum span. The first element of an array adds the width division and
// the first draw, and the last adds the pivot read. A two beat input queue keeps
// accepting while the back end works, until the queue is full.
module stratified_sample_median_pivot (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               first,
	input  logic [ssmp_pkg::POS_W-1:0]         length,
	input  logic signed [ssmp_pkg::ELEM_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ssmp_pkg::ELEM_W-1:0] pivot_value,
	output logic [ssmp_pkg::POS_W-1:0]         pivot_index
);
	import ssmp_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_pop;

	assign cfg_ready = 1'b1;
	assign in_item   = item_t'{first, length, value};

	ssmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ssmp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pivot_value (pivot_value),
		.pivot_index (pivot_index)
	);
endmodule
